// ===== sv/mtrm_pkg.sv =====
// Shared constants, field widths and controller/datapath interface types.
package mtrm_pkg;

    localparam int RANGE_ENTRIES_DEFAULT = 8;

    localparam int KIND_W   = 1;
    localparam int INDEX_W  = 3;
    localparam int TYPE_W   = 8;
    localparam int FRAME_W  = 36;
    localparam int ADDR_W   = 48;
    localparam int PAGE_W   = 52;
    localparam int COUNT_W  = 4;
    localparam int FRAME_SHIFT = 12;

    // Size of the queried page, minus one, at the width of the page end.
    localparam logic [PAGE_W:0] PAGE_SPAN = (PAGE_W + 1)'(32'h001F_FFFF);

    localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    typedef struct packed {
        logic capture;
        logic load_write;
        logic scan_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
    } dp_status_t;

endpackage

// ===== sv/mtrm_ctrl.sv =====
// Controller state machine that sequences loads and query scans.
module mtrm_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mtrm_pkg::KIND_W-1:0]      kind,
    input  mtrm_pkg::dp_status_t             status,
    output mtrm_pkg::ctrl_cmd_t              cmd,
    output logic                             busy,
    output logic                             done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == mtrm_pkg::KIND_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (status.count_zero)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign cmd.capture    = (state_reg == ST_IDLE) && start;
    assign cmd.load_write = (state_reg == ST_LOAD);
    assign cmd.scan_step  = (state_reg == ST_SCAN);
    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;

endmodule

// ===== sv/mtrm_datapath.sv =====
// Range table, load arithmetic and the one-entry-per-cycle query scan.
module mtrm_datapath
#(
    parameter int RANGE_ENTRIES = mtrm_pkg::RANGE_ENTRIES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtrm_pkg::ctrl_cmd_t                 cmd,
    output mtrm_pkg::dp_status_t                status,
    input  logic                                cfg_write,
    input  logic [mtrm_pkg::COUNT_W-1:0]        cfg_data,
    input  logic [mtrm_pkg::INDEX_W-1:0]        range_index,
    input  logic [mtrm_pkg::TYPE_W-1:0]         range_type,
    input  logic                                range_enabled,
    input  logic [mtrm_pkg::FRAME_W-1:0]        base_frame,
    input  logic [mtrm_pkg::FRAME_W-1:0]        mask_frame,
    input  logic [mtrm_pkg::PAGE_W-1:0]         page_address,
    input  logic [mtrm_pkg::TYPE_W-1:0]         fallback_type,
    output logic [mtrm_pkg::TYPE_W-1:0]         memory_type
);

    localparam int IDX_W = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(RANGE_ENTRIES + 1);
    localparam int CMP_W = ((mtrm_pkg::COUNT_W > mtrm_pkg::INDEX_W) ?
                            mtrm_pkg::COUNT_W : mtrm_pkg::INDEX_W) + 2;
    localparam logic [CMP_W-1:0] DEPTH = CMP_W'(RANGE_ENTRIES);
    localparam int ADDR_W = mtrm_pkg::ADDR_W;
    localparam int PAGE_W = mtrm_pkg::PAGE_W;

    // Range table. Only the valid bits need a reset; the rest is read only
    // behind a set valid bit.
    logic [ADDR_W-1:0]               entry_base_reg  [RANGE_ENTRIES];
    logic [ADDR_W-1:0]               entry_end_reg   [RANGE_ENTRIES];
    logic [mtrm_pkg::TYPE_W-1:0]     entry_type_reg  [RANGE_ENTRIES];
    logic [RANGE_ENTRIES-1:0]        entry_valid_reg;

    logic [mtrm_pkg::COUNT_W-1:0]    range_count_reg;

    // Captured command beat.
    logic [mtrm_pkg::INDEX_W-1:0]    index_reg;
    logic                            index_ok_reg;
    logic [mtrm_pkg::TYPE_W-1:0]     type_reg;
    logic                            enable_ok_reg;
    logic [ADDR_W-1:0]               start_reg;
    logic [mtrm_pkg::FRAME_W-1:0]    lowbit_reg;
    logic [PAGE_W-1:0]               addr_reg;
    logic [PAGE_W:0]                 last_reg;
    logic [mtrm_pkg::TYPE_W-1:0]     cand_reg;
    logic [CNT_W-1:0]                scan_count_reg;
    logic [IDX_W-1:0]                scan_idx_reg;

    logic [mtrm_pkg::FRAME_W-1:0]    lowbit;
    logic [CMP_W-1:0]                count_wide;
    logic [CNT_W-1:0]                scan_count;
    logic [ADDR_W:0]                 end_sum;
    logic [ADDR_W-1:0]               end_sat;
    logic [IDX_W-1:0]                wr_idx;
    logic                            hit;

    // Isolate the lowest set bit of the mask: it gives the range size.
    assign lowbit = mask_frame & (~mask_frame + mtrm_pkg::FRAME_W'(1));

    assign count_wide = CMP_W'(range_count_reg);
    assign scan_count = (count_wide > DEPTH) ? CNT_W'(RANGE_ENTRIES)
                                             : CNT_W'(range_count_reg);

    assign end_sum = {1'b0, start_reg}
                   + {1'b0, lowbit_reg, {mtrm_pkg::FRAME_SHIFT{1'b0}}}
                   - (ADDR_W + 1)'(1);
    assign end_sat = end_sum[ADDR_W] ? {ADDR_W{1'b1}} : end_sum[ADDR_W-1:0];

    assign wr_idx = IDX_W'(index_reg);

    assign hit = entry_valid_reg[scan_idx_reg]
              && (last_reg >= (PAGE_W + 1)'(entry_base_reg[scan_idx_reg]))
              && (PAGE_W'(entry_end_reg[scan_idx_reg]) >= addr_reg);

    assign status.count_zero = (range_count_reg == '0);
    assign status.scan_last  = (CNT_W'(scan_idx_reg) == scan_count_reg - CNT_W'(1));

    assign memory_type = cand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_count_reg <= '0;
            entry_valid_reg <= '0;
            scan_idx_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                range_count_reg <= cfg_data;
            end
            if (cmd.load_write && index_ok_reg)
            begin
                entry_valid_reg[wr_idx] <= enable_ok_reg;
            end
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            index_reg      <= range_index;
            index_ok_reg   <= (CMP_W'(range_index) < DEPTH);
            type_reg       <= range_type;
            enable_ok_reg  <= range_enabled && (mask_frame != '0);
            start_reg      <= {base_frame, {mtrm_pkg::FRAME_SHIFT{1'b0}}};
            lowbit_reg     <= lowbit;
            addr_reg       <= page_address;
            last_reg       <= {1'b0, page_address} + mtrm_pkg::PAGE_SPAN;
            cand_reg       <= fallback_type;
            scan_count_reg <= scan_count;
        end
        else if (cmd.scan_step && hit)
        begin
            cand_reg <= entry_type_reg[scan_idx_reg];
        end
        if (cmd.load_write && index_ok_reg)
        begin
            entry_type_reg[wr_idx] <= type_reg;
            if (enable_ok_reg)
            begin
                entry_base_reg[wr_idx] <= start_reg;
                entry_end_reg[wr_idx]  <= end_sat;
            end
        end
    end

endmodule

// ===== sv/memory_type_range_match.sv =====
// Top level of the variable memory-type range table with 2MB page lookup.
//
// A beat is taken when start is high and busy is low. A load beat (kind 0)
// keeps busy high in the load state while the range end is formed and the
// entry is written; it gives no result. A query beat (kind 1) scans the first
// min(range_count, RANGE_ENTRIES) entries, one entry per cycle through the
// single compare unit of the datapath, with busy high throughout the scan;
// done then pulses for one cycle with memory_type, and that cycle can
// already take the next beat. A query with a range count of zero skips the
// scan and returns its fallback type in the cycle after acceptance. The
// receiver cannot stall: memory_type is valid only in the cycle that done
// is high. The range count register is written through the cfg channel,
// which is always ready; write it only while the block is idle.
module memory_type_range_match
#(
    parameter int RANGE_ENTRIES = mtrm_pkg::RANGE_ENTRIES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mtrm_pkg::KIND_W-1:0]         kind,
    input  logic [mtrm_pkg::INDEX_W-1:0]        range_index,
    input  logic [mtrm_pkg::TYPE_W-1:0]         range_type,
    input  logic                                range_enabled,
    input  logic [mtrm_pkg::FRAME_W-1:0]        base_frame,
    input  logic [mtrm_pkg::FRAME_W-1:0]        mask_frame,
    input  logic [mtrm_pkg::PAGE_W-1:0]         page_address,
    input  logic [mtrm_pkg::TYPE_W-1:0]         fallback_type,
    output logic                                done,
    output logic [mtrm_pkg::TYPE_W-1:0]         memory_type,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtrm_pkg::COUNT_W-1:0]        cfg_data
);

    mtrm_pkg::ctrl_cmd_t  cmd;
    mtrm_pkg::dp_status_t status;

    // The register can be written in any cycle.
    assign cfg_ready = 1'b1;

    mtrm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mtrm_datapath
    #(
        .RANGE_ENTRIES (RANGE_ENTRIES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .range_index    (range_index),
        .range_type     (range_type),
        .range_enabled  (range_enabled),
        .base_frame     (base_frame),
        .mask_frame     (mask_frame),
        .page_address   (page_address),
        .fallback_type  (fallback_type),
        .memory_type    (memory_type)
    );

endmodule

// ===== sv/mtrm_checker.sv =====
// Port-level checks of the range lookup block, bound to its top level.
module mtrm_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [mtrm_pkg::KIND_W-1:0]         kind,
    input  logic                                done
);

    // A result never shows while a command is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // A load beat gives no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == mtrm_pkg::KIND_LOAD) |=> !done)
        else $error("load produced a result");

    // A query beat either starts a scan or answers at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == mtrm_pkg::KIND_QUERY) |=> (busy || done))
        else $error("query neither scanned nor answered");

    // The block only goes busy after taking a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without an accepted beat");

endmodule

bind memory_type_range_match mtrm_checker u_mtrm_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .kind  (kind),
    .done  (done)
);

// ===== tb/range_type_checker.sv =====
// Checker that predicts and compares the resolved memory type of each page query.
module range_type_checker
    import mtrm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [INDEX_W-1:0]  range_index,
    input  logic [TYPE_W-1:0]   range_type,
    input  logic                range_enabled,
    input  logic [FRAME_W-1:0]  base_frame,
    input  logic [FRAME_W-1:0]  mask_frame,
    input  logic [PAGE_W-1:0]   page_address,
    input  logic [TYPE_W-1:0]   fallback_type,
    input  logic                done,
    input  logic [TYPE_W-1:0]   memory_type,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data,
    output int                  mismatches,
    output int                  outstanding
);

    localparam int          DEPTH      = RANGE_ENTRIES_DEFAULT;
    localparam logic [63:0] ADDR_TOP   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] PAGE_BYTES = 64'h0000_0000_0020_0000;

    logic [ADDR_W-1:0]  span_base [DEPTH];
    logic [ADDR_W-1:0]  span_end  [DEPTH];
    logic [TYPE_W-1:0]  span_type [DEPTH];
    logic               span_live [DEPTH];
    logic [COUNT_W-1:0] scan_count;
    logic [TYPE_W-1:0]  expected_types [$];

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // A disabled entry or one with a zero mask keeps its old bounds and only
    // loses its valid bit; the type is written in every case.
    function automatic void store_range(input logic [INDEX_W-1:0] idx,
                                        input logic [TYPE_W-1:0] typ,
                                        input logic en,
                                        input logic [FRAME_W-1:0] base,
                                        input logic [FRAME_W-1:0] mask);
        logic [63:0] lo;
        logic [63:0] m;
        logic [63:0] size;
        logic [63:0] hi;
        if (int'(idx) >= DEPTH)
            return;
        span_type[idx] = typ;
        if (!en || mask == '0)
        begin
            span_live[idx] = 1'b0;
            return;
        end
        m    = 64'(mask);
        lo   = 64'(base) << FRAME_SHIFT;
        size = (m & (~m + 64'd1)) << FRAME_SHIFT;
        hi   = lo + size - 64'd1;
        if (hi > ADDR_TOP)
            hi = ADDR_TOP;
        span_base[idx] = lo[ADDR_W-1:0];
        span_end[idx]  = hi[ADDR_W-1:0];
        span_live[idx] = 1'b1;
    endfunction

    // The last live entry in scan range that overlaps the page decides the type.
    function automatic logic [TYPE_W-1:0] resolve_page_type(
        input logic [PAGE_W-1:0] addr,
        input logic [TYPE_W-1:0] cand);
        logic [63:0]       first;
        logic [63:0]       last;
        int                n;
        logic [TYPE_W-1:0] pick;
        first = 64'(addr);
        last  = first + PAGE_BYTES - 64'd1;
        n     = (int'(scan_count) > DEPTH) ? DEPTH : int'(scan_count);
        pick  = cand;
        for (int i = 0; i < n; i++)
        begin
            if (span_live[i] && last >= 64'(span_base[i]) && first <= 64'(span_end[i]))
                pick = span_type[i];
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [TYPE_W-1:0] want;
        int                pushed;
        int                popped;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                span_base[i] = '0;
                span_end[i]  = '0;
                span_type[i] = '0;
                span_live[i] = 1'b0;
            end
            scan_count = '0;
            expected_types.delete();
            outstanding <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            if (done)
            begin
                if (expected_types.size() == 0)
                begin
                    report_mismatch($sformatf("memory_type %0h with no query waiting",
                                              memory_type));
                end
                else
                begin
                    want   = expected_types.pop_front();
                    popped = 1;
                    if (memory_type !== want)
                        report_mismatch($sformatf("memory_type %0h, expected %0h",
                                                  memory_type, want));
                end
            end
            if (cfg_valid && cfg_ready)
                scan_count = cfg_data;
            if (start && !busy)
            begin
                if (kind == KIND_QUERY)
                begin
                    expected_types.push_back(resolve_page_type(page_address,
                                                               fallback_type));
                    pushed = 1;
                end
                else
                begin
                    store_range(range_index, range_type, range_enabled, base_frame,
                                mask_frame);
                end
            end
            outstanding <= outstanding + pushed - popped;
        end
    end

endmodule

// ===== tb/tb_memory_type_range_match.sv =====
// Testbench top that drives range loads, page queries and range count writes.
module tb_memory_type_range_match;

    import mtrm_pkg::*;

    // Half period of the 20 unit clock, and a run limit far beyond the
    // slowest correct run (about 650 beats, each at most a random gap plus
    // a full table scan).
    localparam int CLK_HALF     = 10;
    localparam int LIMIT_CYCLES = 500000;
    localparam int PHASES       = 12;
    localparam int PHASE_BEATS  = 50;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [KIND_W-1:0]  kind           = KIND_LOAD;
    logic [INDEX_W-1:0] range_index    = '0;
    logic [TYPE_W-1:0]  range_type     = '0;
    logic               range_enabled  = 1'b0;
    logic [FRAME_W-1:0] base_frame     = '0;
    logic [FRAME_W-1:0] mask_frame     = '0;
    logic [PAGE_W-1:0]  page_address   = '0;
    logic [TYPE_W-1:0]  fallback_type  = '0;
    logic               done;
    logic [TYPE_W-1:0]  memory_type;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data       = '0;
    int                 mismatches;
    int                 outstanding;

    // Base frames of the most recent load at each index, so that many random
    // queries land on, next to or across a range that is actually loaded.
    logic [FRAME_W-1:0] aim_frames [8];

    memory_type_range_match u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .range_index    (range_index),
        .range_type     (range_type),
        .range_enabled  (range_enabled),
        .base_frame     (base_frame),
        .mask_frame     (mask_frame),
        .page_address   (page_address),
        .fallback_type  (fallback_type),
        .done           (done),
        .memory_type    (memory_type),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    range_type_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .range_index    (range_index),
        .range_type     (range_type),
        .range_enabled  (range_enabled),
        .base_frame     (base_frame),
        .mask_frame     (mask_frame),
        .page_address   (page_address),
        .fallback_type  (fallback_type),
        .done           (done),
        .memory_type    (memory_type),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Present one beat and hold it until the block takes it. Start is left
    // high on return so that back-to-back beats need no second assignment in
    // the same step; the gap and settle tasks are the only places that lower it.
    task automatic send_beat(input logic [KIND_W-1:0] k,
                             input logic [INDEX_W-1:0] idx,
                             input logic [TYPE_W-1:0] typ,
                             input logic en,
                             input logic [FRAME_W-1:0] base,
                             input logic [FRAME_W-1:0] mask,
                             input logic [PAGE_W-1:0] addr,
                             input logic [TYPE_W-1:0] cand);
        start          <= 1'b1;
        kind           <= k;
        range_index    <= idx;
        range_type     <= typ;
        range_enabled  <= en;
        base_frame     <= base;
        mask_frame     <= mask;
        page_address   <= addr;
        fallback_type  <= cand;
        if (k == KIND_LOAD)
            aim_frames[idx] = base;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Idle the command side for a random stretch: mostly none or a few
    // cycles, now and then a long one. Burst phases take no gap here.
    task automatic take_gap(input bit burst);
        int gap;
        int pick;
        gap  = 0;
        pick = $urandom_range(0, 9);
        if (!burst)
        begin
            if (pick >= 9)
                gap = $urandom_range(8, 40);
            else if (pick >= 6)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every query has returned its type. A load
    // gives no result but keeps the block busy while it writes the entry, so a
    // few further cycles pass before the block counts as idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The range count register is only ever written with the block idle.
    task automatic set_range_count(input logic [COUNT_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [COUNT_W-1:0] phase_count [PHASES];
        logic [63:0]        rnd_a;
        logic [63:0]        rnd_b;
        logic [63:0]        rnd_c;
        logic [63:0]        aimed;
        logic [INDEX_W-1:0] idx;
        logic [FRAME_W-1:0] base;
        logic [FRAME_W-1:0] mask;
        logic [PAGE_W-1:0]  addr;
        int                 shift;
        int                 pick;
        bit                 burst;

        phase_count = '{4'd8, 4'd15, 4'd0, 4'd1, 4'd8, 4'd4,
                        4'd12, 4'd7, 4'd2, 4'd8, 4'd6, 4'd3};
        for (int i = 0; i < 8; i++)
            aim_frames[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Right after reset the range count is zero, so a
        // query must return its fallback type untouched.
        send_beat(KIND_QUERY, 3'd0, 8'h00, 1'b0, '0, '0, 52'h0, 8'hFF);
        // A 4KB range at address zero, from a mask of all ones.
        send_beat(KIND_LOAD, 3'd0, 8'h06, 1'b1, 36'h0, 36'hF_FFFF_FFFF, '0, 8'h00);
        // Highest base with the largest size: the end runs past 48 bits
        // and has to saturate.
        send_beat(KIND_LOAD, 3'd7, 8'hFF, 1'b1, 36'hF_FFFF_FFFF, 36'h8_0000_0000,
                  '0, 8'h00);
        // A disabled load and an enabled load with a zero mask: both keep
        // the old bounds and can never match.
        send_beat(KIND_LOAD, 3'd1, 8'h00, 1'b0, 36'h1, 36'h1, '0, 8'h00);
        send_beat(KIND_LOAD, 3'd2, 8'h05, 1'b1, 36'h200, 36'h0, '0, 8'h00);
        // A 2MB range from 4MB to 6MB - 1.
        send_beat(KIND_LOAD, 3'd3, 8'hA5, 1'b1, 36'h400, 36'hF_FFFF_FE00, '0, 8'h00);
        send_beat(KIND_QUERY, 3'd0, 8'h00, 1'b0, '0, '0, 52'h0, 8'h00);

        set_range_count(4'd8);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h0, 8'h12);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'hF_FFFF_FFFF_FFFF, 8'h34);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h0_FFFF_FFFF_F000, 8'h34);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h1_0000_0000_0000, 8'h56);
        // Unaligned page whose tail reaches into the 2MB range.
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h3F_F000, 8'h78);
        // One byte past the end of the 2MB range, then its last byte.
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h60_0000, 8'h9A);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h5F_FFFF, 8'h9A);
        // Pages that only meet the disabled and zero mask entries.
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h20_0000, 8'hBC);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h1000, 8'hDE);

        // A count above the table depth scans the whole table.
        set_range_count(4'd15);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h0_FFFF_FFFF_F000, 8'h01);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h0, 8'h01);

        // With a count of one only entry zero takes part.
        set_range_count(4'd1);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h3F_F000, 8'h02);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h0, 8'h02);
        // Disabling entry zero leaves its bounds but takes it out of play.
        send_beat(KIND_LOAD, 3'd0, 8'h77, 1'b0, 36'hF_FFFF_FFFF, 36'h1, '0, 8'h00);
        send_beat(KIND_QUERY, '0, '0, 1'b0, '0, '0, 52'h0, 8'h03);

        // Random part: phases of loads and queries, each under its own range
        // count. Every third phase runs with no random gaps between its beats.
        for (int p = 0; p < PHASES; p++)
        begin
            set_range_count(p < 6 ? phase_count[p] : COUNT_W'($urandom_range(0, 15)));
            burst = (p % 3 == 2);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Now and then hold off until every query has come back.
                if ($urandom_range(0, 99) < 3)
                    settle();
                take_gap(burst);
                rnd_a = {$urandom(), $urandom()};
                rnd_b = {$urandom(), $urandom()};
                rnd_c = {$urandom(), $urandom()};
                idx   = INDEX_W'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < 40)
                begin
                    // Bases cluster in the low 16MB half of the time so
                    // that ranges overlap and the later entry has to win.
                    base  = ($urandom_range(0, 1) == 0) ? FRAME_W'($urandom_range(0, 4095))
                                                        : rnd_a[FRAME_W-1:0];
                    shift = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                       : $urandom_range(0, 35);
                    mask  = (rnd_b[FRAME_W-1:0] << shift) | (FRAME_W'(1) << shift);
                    if ($urandom_range(0, 9) == 0)
                        mask = '0;
                    send_beat(KIND_LOAD, idx, rnd_c[7:0], $urandom_range(0, 9) != 0,
                              base, mask, rnd_c[PAGE_W+7:8], rnd_c[63:56]);
                end
                else
                begin
                    pick = $urandom_range(0, 3);
                    if (pick < 2)
                    begin
                        // Within 4MB either side of a loaded base.
                        aimed = (64'(aim_frames[idx]) << FRAME_SHIFT)
                              + 64'($urandom_range(0, 32'h80_0000)) - 64'h40_0000;
                        addr  = aimed[PAGE_W-1:0];
                    end
                    else if (pick == 2)
                    begin
                        addr = PAGE_W'($urandom_range(0, 32'h0100_0000));
                    end
                    else
                    begin
                        addr = rnd_a[PAGE_W-1:0];
                    end
                    send_beat(KIND_QUERY, rnd_b[2:0], rnd_b[10:3], rnd_b[11],
                              rnd_b[FRAME_W+11:12], rnd_c[FRAME_W-1:0], addr, rnd_c[63:56]);
                end
            end
        end

        // Let the last query come back, then give the block a few more
        // cycles to show any stray result.
        settle();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== memory_type_range_match.f =====
sv/mtrm_pkg.sv
sv/mtrm_ctrl.sv
sv/mtrm_datapath.sv
sv/memory_type_range_match.sv
sv/mtrm_checker.sv
tb/range_type_checker.sv
tb/tb_memory_type_range_match.sv
